[design/gha_pkg.sv]
// Shared types and constants of the generational handle allocator.
`default_nettype none

package gha_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned GenW     = 16;
  localparam int unsigned CountW   = 11;
  localparam int unsigned MetaW    = GenW + 1;

  localparam logic [1:0] OpAlloc  = 2'd0;
  localparam logic [1:0] OpFree   = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusFull      = 2'd1;
  localparam logic [1:0] StatusBadHandle = 2'd2;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StExec = 3'b010,
    StPop  = 3'b100
  } gha_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_issue;  // capture the item and read all tables
    logic pop_rd;    // read the slot word of the slot popped from the free stack
    logic commit;    // update state and load the result register
  } gha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_needed;  // allocate that reuses a slot from the free stack
    logic out_free;    // result register can take a new result this cycle
  } gha_stat_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  slot_index;
    logic [GenW-1:0]   generation;
    logic [SlotW-1:0]  dense_index;
    logic              move_valid;
    logic [SlotW-1:0]  moved_from;
    logic [SlotW-1:0]  moved_slot;
    logic [CountW-1:0] live_count;
  } gha_result_t;

endpackage

`default_nettype wire

[design/generational_handle_allocator.sv]
// Top level of the generational handle allocator: stream ports, controller and datapath.
`default_nettype none

// Generational slot map with 1024 slots and 16-bit generations. Each input
// transfer is one operation (allocate, free or lookup) and gives exactly one
// result transfer. Lookup, free and allocating a fresh slot read all tables
// on accept and then commit; allocating a slot reused from the free stack
// adds a pop step between them, because the popped slot number must come out
// of the free-stack memory before its generation can be read from the slot
// memory. Tables sit in single-read-port RAMs with registered reads. The next
// item is taken as soon as the previous one has committed, even while its
// result still waits in the output register; a commit waits only when that
// register is still full. No clearing pass runs after reset: slots at or
// above the high watermark are treated as never allocated.
module generational_handle_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] handle_slot, [25:10] handle_generation, [31:26] zero
  input  wire  [31:0] s_axis_tdata,
  // [1:0] opcode
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [9:0] slot_index, [25:10] generation, [35:26] dense_index,
  // [45:36] moved_from, [55:46] moved_slot, [66:56] live_count, [71:67] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] status, [2] move_valid
  output logic [2:0]  m_axis_tuser
);

  gha_pkg::gha_cmd_t    cmd;
  gha_pkg::gha_stat_t   stat;
  gha_pkg::gha_result_t res;

  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gha_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser),
    .in_slot_i   (s_axis_tdata[9:0]),
    .in_gen_i    (s_axis_tdata[25:10]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'b0, res.live_count, res.moved_slot, res.moved_from,
                         res.dense_index, res.generation, res.slot_index};
  assign m_axis_tuser = {res.move_valid, res.status};

  // Only one item is in flight: an accepted transfer drops ready next cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is still in flight");

  // A commit never overwrites a result that has not been transferred.
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> stat.out_free)
    else $error("commit while the result register is still full");

  // Every commit shows a result in the next cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("commit did not produce a result");

  // The live count never exceeds the number of slots.
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[66:56] <= 11'd1024)
    else $error("live count above table size");

endmodule

`default_nettype wire

[design/gha_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module gha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(Depth)-1:0]   waddr_i,
  input  wire [Width-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/gha_ctrl.sv]
// Controller state machine that sequences reads, the free-stack pop and the commit.
`default_nettype none

module gha_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  gha_pkg::gha_stat_t stat_i,
  output gha_pkg::gha_cmd_t  cmd_o
);

  gha_pkg::gha_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gha_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = gha_pkg::StExec;
        end
      end
      gha_pkg::StExec: begin
        if (stat_i.pop_needed) begin
          cmd_o.pop_rd = 1'b1;
          state_d      = gha_pkg::StPop;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = gha_pkg::StIdle;
        end
      end
      gha_pkg::StPop: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = gha_pkg::StIdle;
        end
      end
      default: begin
        state_d = gha_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gha_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[design/gha_datapath.sv]
// Datapath: slot, dense and free-stack tables, counters and the result register.
`default_nettype none

module gha_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  gha_pkg::gha_cmd_t             cmd_i,
  output gha_pkg::gha_stat_t            stat_o,
  input  wire [1:0]                     in_op_i,
  input  wire [gha_pkg::SlotW-1:0]      in_slot_i,
  input  wire [gha_pkg::GenW-1:0]       in_gen_i,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output gha_pkg::gha_result_t          res_o
);

  localparam int unsigned SlotW  = gha_pkg::SlotW;
  localparam int unsigned GenW   = gha_pkg::GenW;
  localparam int unsigned CountW = gha_pkg::CountW;
  localparam int unsigned MetaW  = gha_pkg::MetaW;

  // Captured item.
  logic [1:0]       op_q;
  logic [SlotW-1:0] hs_q;
  logic [GenW-1:0]  hg_q;

  logic [CountW-1:0] free_depth_q, free_depth_d;
  logic [CountW-1:0] watermark_q, watermark_d;
  logic [CountW-1:0] live_total_q, live_total_d;

  logic                 out_valid_q;
  gha_pkg::gha_result_t res_q, res_d;

  // Table ports.
  logic             meta_we, meta_re;
  logic [SlotW-1:0] meta_waddr, meta_raddr;
  logic [MetaW-1:0] meta_wdata, meta_rdata;
  logic             pos_we;
  logic [SlotW-1:0] pos_waddr, pos_wdata, pos_rdata;
  logic             own_we;
  logic [SlotW-1:0] own_waddr, own_wdata, own_rdata;
  logic             stk_we;
  logic [SlotW-1:0] stk_waddr, stk_wdata, stk_rdata;

  logic [CountW-1:0] last_w, top_w;
  logic              meta_live;
  logic [GenW-1:0]   meta_gen;
  logic              handle_ok;
  logic              alloc_ok;
  logic [SlotW-1:0]  new_slot;
  logic [GenW-1:0]   new_gen;
  logic [GenW-1:0]   bumped_gen;

  assign last_w     = CountW'(live_total_q - CountW'(1));
  assign top_w      = CountW'(free_depth_q - CountW'(1));
  assign meta_live  = meta_rdata[MetaW-1];
  assign meta_gen   = meta_rdata[GenW-1:0];
  assign bumped_gen = GenW'(meta_gen + GenW'(1));

  // A slot at or above the watermark was never handed out, so its live bit is
  // taken as clear whatever the table holds.
  assign handle_ok = (CountW'(hs_q) < watermark_q) && meta_live && (meta_gen == hg_q);

  // The slot word is read at the handle on accept, or at the popped slot.
  assign meta_re    = cmd_i.rd_issue | cmd_i.pop_rd;
  assign meta_raddr = cmd_i.pop_rd ? stk_rdata : in_slot_i;

  always_comb begin
    meta_we      = 1'b0;
    meta_waddr   = hs_q;
    meta_wdata   = '0;
    pos_we       = 1'b0;
    pos_waddr    = hs_q;
    pos_wdata    = '0;
    own_we       = 1'b0;
    own_waddr    = '0;
    own_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = free_depth_q[SlotW-1:0];
    stk_wdata    = hs_q;
    free_depth_d = free_depth_q;
    watermark_d  = watermark_q;
    live_total_d = live_total_q;
    alloc_ok     = 1'b0;
    new_slot     = '0;
    new_gen      = '0;
    res_d        = '0;
    res_d.status = gha_pkg::StatusBadHandle;
    case (op_q)
      gha_pkg::OpAlloc: begin
        if (free_depth_q != '0) begin
          alloc_ok     = 1'b1;
          new_slot     = stk_rdata;
          new_gen      = meta_gen;
          free_depth_d = top_w;
        end else if (watermark_q < CountW'(gha_pkg::MaxSlots)) begin
          alloc_ok    = 1'b1;
          new_slot    = watermark_q[SlotW-1:0];
          new_gen     = '0;
          watermark_d = CountW'(watermark_q + CountW'(1));
        end
        if (alloc_ok) begin
          meta_we           = 1'b1;
          meta_waddr        = new_slot;
          meta_wdata        = {1'b1, new_gen};
          pos_we            = 1'b1;
          pos_waddr         = new_slot;
          pos_wdata         = live_total_q[SlotW-1:0];
          own_we            = 1'b1;
          own_waddr         = live_total_q[SlotW-1:0];
          own_wdata         = new_slot;
          live_total_d      = CountW'(live_total_q + CountW'(1));
          res_d.status      = gha_pkg::StatusOk;
          res_d.slot_index  = new_slot;
          res_d.generation  = new_gen;
          res_d.dense_index = live_total_q[SlotW-1:0];
        end else begin
          res_d.status = gha_pkg::StatusFull;
        end
      end
      gha_pkg::OpFree: begin
        if (handle_ok && (live_total_q != '0)) begin
          // Fill the hole with the last dense entry unless the hole is the last.
          if (pos_rdata != last_w[SlotW-1:0]) begin
            pos_we           = 1'b1;
            pos_waddr        = own_rdata;
            pos_wdata        = pos_rdata;
            own_we           = 1'b1;
            own_waddr        = pos_rdata;
            own_wdata        = own_rdata;
            res_d.move_valid = 1'b1;
            res_d.moved_from = last_w[SlotW-1:0];
            res_d.moved_slot = own_rdata;
          end
          meta_we    = 1'b1;
          meta_waddr = hs_q;
          meta_wdata = {1'b0, bumped_gen};
          if (free_depth_q < CountW'(gha_pkg::MaxSlots)) begin
            stk_we       = 1'b1;
            free_depth_d = CountW'(free_depth_q + CountW'(1));
          end
          live_total_d      = last_w;
          res_d.status      = gha_pkg::StatusOk;
          res_d.slot_index  = hs_q;
          res_d.generation  = bumped_gen;
          res_d.dense_index = pos_rdata;
        end
      end
      gha_pkg::OpLookup: begin
        if (handle_ok) begin
          res_d.status      = gha_pkg::StatusOk;
          res_d.slot_index  = hs_q;
          res_d.generation  = meta_gen;
          res_d.dense_index = pos_rdata;
        end
      end
      default: begin
      end
    endcase
    res_d.live_count = live_total_d;
  end

  gha_ram #(.Width(MetaW), .Depth(gha_pkg::MaxSlots)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we & cmd_i.commit),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  gha_ram #(.Width(SlotW), .Depth(gha_pkg::MaxSlots)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we & cmd_i.commit),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (in_slot_i),
    .rdata_o (pos_rdata)
  );

  gha_ram #(.Width(SlotW), .Depth(gha_pkg::MaxSlots)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we & cmd_i.commit),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (last_w[SlotW-1:0]),
    .rdata_o (own_rdata)
  );

  gha_ram #(.Width(SlotW), .Depth(gha_pkg::MaxSlots)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we & cmd_i.commit),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (top_w[SlotW-1:0]),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      op_q <= in_op_i;
      hs_q <= in_slot_i;
      hg_q <= in_gen_i;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_depth_q <= '0;
      watermark_q  <= '0;
      live_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        free_depth_q <= free_depth_d;
        watermark_q  <= watermark_d;
        live_total_q <= live_total_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.pop_needed = (op_q == gha_pkg::OpAlloc) && (free_depth_q != '0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign res_o             = res_q;

endmodule

`default_nettype wire
